[hw/rtl/t8bm_pkg.sv]
// Shared types and constants for the 8-ary bitmap tree membership block.
// Holds configuration register indexes, field widths and the child picker.
// No dependencies.
package t8bm_pkg;

  localparam int BYTE_W     = 8;
  localparam int DIGIT_W    = 3;
  localparam int FILE_W     = 18;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int LEVELS_W   = 3;

  typedef logic [BYTE_W-1:0]     tree_byte_t;
  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [FILE_W-1:0]     file_num_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_index_t;

  // Configuration register indexes
  localparam cfg_index_t CFG_TREE_LEVELS    = 2'd0;
  localparam cfg_index_t CFG_FIRST_FILE     = 2'd1;
  localparam cfg_index_t CFG_SECOND_FILE    = 2'd2;
  localparam cfg_index_t CFG_SECOND_ENABLED = 2'd3;

  // Lowest set bit of a child mask; an empty mask gives the last digit.
  function automatic digit_t lowest_child(input tree_byte_t mask);
    digit_t k;
    k = digit_t'(BYTE_W - 1);
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      if (mask[b]) k = digit_t'(b);
    end
    return k;
  endfunction

endpackage

[hw/rtl/tree8_bitmap_membership.sv]
// Top level of the 8-ary bitmap tree membership test.
// Walks a preorder byte stream of a bitmap tree; one result per finished tree.
// Depends on t8bm_pkg.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  byte      | byte_valid, byte_ready, tree_byte         | in
//  result    | result_valid, result_ready, hit_first,    | out
//            | hit_second, selected                      |
//  cfg       | cfg_write, cfg_index, cfg_data            | in
//
// Every byte request is handled in the cycle it is accepted: one byte per cycle
// while no result is stalled, set by the single pass from the level stack
// registers to the result register, which loads on a tree's last byte.
// Reset clears the configuration to its defaults, empties the level stack and
// waits for a root byte. A stalled result holds in the result register; new
// bytes are still taken as long as that register is empty or being drained.
module tree8_bitmap_membership #(
  parameter int MAX_LEVELS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_ready,
  input  logic [7:0]                tree_byte,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      hit_first,
  output logic                      hit_second,
  output logic                      selected,
  input  logic                      cfg_write,
  input  t8bm_pkg::cfg_index_t      cfg_index,
  input  t8bm_pkg::cfg_data_t       cfg_data
);

  // Width of a level number (0 .. MAX_LEVELS-1)
  localparam int DW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  // Width of a level count (1 .. MAX_LEVELS)
  localparam int CW  = $clog2(MAX_LEVELS + 1) + 1;
  // Width of a digit shift amount, three bits per level
  localparam int SHW = DW + 2;

  typedef logic [DW-1:0] level_t;

  // Configuration registers
  logic [t8bm_pkg::LEVELS_W-1:0] tree_levels;
  t8bm_pkg::file_num_t           first_file;
  t8bm_pkg::file_num_t           second_file;
  logic                          second_enabled;

  // Level stack and walk state
  t8bm_pkg::tree_byte_t pending_children [MAX_LEVELS];
  t8bm_pkg::digit_t     path_digits      [MAX_LEVELS];
  level_t               current_depth;
  logic                 found_first;
  logic                 found_second;

  t8bm_pkg::tree_byte_t pending_children_next [MAX_LEVELS];
  t8bm_pkg::digit_t     path_digits_next      [MAX_LEVELS];
  level_t               current_depth_next;
  logic                 found_first_next;
  logic                 found_second_next;

  logic                 byte_accept;
  logic [CW-1:0]        levels_clamped;
  level_t               last_level;
  level_t               depth_eff;
  logic                 at_leaf;
  logic                 inner_descend;
  logic                 pop_found;
  level_t               pop_level;
  logic                 tree_done;
  logic [MAX_LEVELS-1:0] match_first;
  logic [MAX_LEVELS-1:0] match_second;
  logic [MAX_LEVELS-1:0] below_depth;
  logic                 leaf_hit_first;
  logic                 leaf_hit_second;
  level_t               level_gap;
  logic [SHW-1:0]       shamt;
  t8bm_pkg::file_num_t  first_shifted;
  t8bm_pkg::file_num_t  second_shifted;
  t8bm_pkg::digit_t     take_digit;
  t8bm_pkg::tree_byte_t take_mask;

  assign byte_ready  = !result_valid || result_ready;
  assign byte_accept = byte_valid && byte_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_levels    <= t8bm_pkg::LEVELS_W'(1);
      first_file     <= '0;
      second_file    <= '0;
      second_enabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        t8bm_pkg::CFG_TREE_LEVELS:
          tree_levels <= cfg_data[t8bm_pkg::LEVELS_W-1:0];
        t8bm_pkg::CFG_FIRST_FILE:
          first_file <= cfg_data[t8bm_pkg::FILE_W-1:0];
        t8bm_pkg::CFG_SECOND_FILE:
          second_file <= cfg_data[t8bm_pkg::FILE_W-1:0];
        t8bm_pkg::CFG_SECOND_ENABLED:
          second_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the level count to 1 .. MAX_LEVELS; the leaf sits at the last level.
  always_comb begin
    levels_clamped = CW'(tree_levels);
    if (levels_clamped == '0) levels_clamped = CW'(1);
    if (levels_clamped > CW'(MAX_LEVELS)) levels_clamped = CW'(MAX_LEVELS);
    last_level = DW'(levels_clamped - CW'(1));
    // A depth past the last level (levels lowered mid-tree) reads as a leaf.
    depth_eff  = (current_depth > last_level) ? last_level : current_depth;
    at_leaf    = (depth_eff == last_level);
  end

  // Compare the stored path with each file's octal digits, level by level.
  // The most significant used digit picks the root's child.
  always_comb begin
    level_gap      = '0;
    shamt          = '0;
    first_shifted  = '0;
    second_shifted = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      level_gap       = last_level - DW'(i);
      shamt           = (SHW'(level_gap) << 1) + SHW'(level_gap);
      first_shifted   = first_file >> shamt;
      second_shifted  = second_file >> shamt;
      match_first[i]  = (path_digits[i] == first_shifted[t8bm_pkg::DIGIT_W-1:0]);
      match_second[i] = (path_digits[i] == second_shifted[t8bm_pkg::DIGIT_W-1:0]);
      below_depth[i]  = (DW'(i) < depth_eff);
    end
    // At the leaf level the file's lowest digit picks the bitmap bit.
    leaf_hit_first  = (&(match_first | ~below_depth))
                      && tree_byte[first_file[t8bm_pkg::DIGIT_W-1:0]];
    leaf_hit_second = (&(match_second | ~below_depth))
                      && tree_byte[second_file[t8bm_pkg::DIGIT_W-1:0]];
  end

  // Pop: deepest ancestor above this byte that still has children pending.
  always_comb begin
    pop_found = 1'b0;
    pop_level = '0;
    for (int e = 0; e < MAX_LEVELS; e++) begin
      if ((DW'(e) < depth_eff) && (pending_children[e] != '0)) begin
        pop_found = 1'b1;
        pop_level = DW'(e);
      end
    end
  end

  assign inner_descend = !at_leaf && (tree_byte != '0);
  assign tree_done     = !inner_descend && !pop_found;

  // Next state of the walk for an accepted byte
  always_comb begin
    pending_children_next = pending_children;
    path_digits_next      = path_digits;
    current_depth_next    = current_depth;
    found_first_next      = found_first;
    found_second_next     = found_second;
    take_digit            = '0;
    take_mask             = '0;

    if (at_leaf) begin
      found_first_next  = found_first  | leaf_hit_first;
      found_second_next = found_second | leaf_hit_second;
    end

    if (inner_descend) begin
      // Record this byte's children and step into the lowest one.
      take_digit                       = t8bm_pkg::lowest_child(tree_byte);
      take_mask                        = t8bm_pkg::tree_byte_t'(1) << take_digit;
      path_digits_next[depth_eff]      = take_digit;
      pending_children_next[depth_eff] = tree_byte & ~take_mask;
      current_depth_next               = depth_eff + DW'(1);
    end else if (pop_found) begin
      // Advance to the next pending sibling at the ancestor level.
      take_digit                       = t8bm_pkg::lowest_child(pending_children[pop_level]);
      take_mask                        = t8bm_pkg::tree_byte_t'(1) << take_digit;
      path_digits_next[pop_level]      = take_digit;
      pending_children_next[pop_level] = pending_children[pop_level] & ~take_mask;
      current_depth_next               = pop_level + DW'(1);
    end else begin
      // Tree finished: drop the hit flags and wait for the next root.
      found_first_next   = 1'b0;
      found_second_next  = 1'b0;
      current_depth_next = '0;
    end
  end

  // Walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        pending_children[i] <= '0;
        path_digits[i]      <= '0;
      end
      current_depth <= '0;
      found_first   <= 1'b0;
      found_second  <= 1'b0;
    end else if (byte_accept) begin
      pending_children <= pending_children_next;
      path_digits      <= path_digits_next;
      current_depth    <= current_depth_next;
      found_first      <= found_first_next;
      found_second     <= found_second_next;
    end
  end

  // Result register: load at the end of a tree, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (byte_accept && tree_done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept && tree_done) begin
      hit_first  <= found_first  | (at_leaf && leaf_hit_first);
      hit_second <= found_second | (at_leaf && leaf_hit_second);
      selected   <= (found_first | (at_leaf && leaf_hit_first))
                    && (!second_enabled || found_second || (at_leaf && leaf_hit_second));
    end
  end

`ifndef SYNTHESIS
  a_done_returns_to_root: assert property (@(posedge clk) disable iff (rst)
    byte_accept && tree_done |=> current_depth == '0 && !found_first && !found_second)
    else $error("walk state not cleared after end of tree");

  a_descend_one_level: assert property (@(posedge clk) disable iff (rst)
    byte_accept && inner_descend |=> current_depth == $past(depth_eff + DW'(1)))
    else $error("inner byte did not step one level down");

  a_selected_needs_first: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !selected || hit_first)
    else $error("selected without first file hit");

  a_pop_goes_up: assert property (@(posedge clk) disable iff (rst)
    byte_accept && !inner_descend && pop_found |=> current_depth <= $past(depth_eff))
    else $error("pop moved below the current level");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !byte_accept)
    else $error("byte taken while a stalled result would be overwritten");
`endif

endmodule
